>>> src/mrl_pkg.sv
package mrl_pkg;

	localparam int DEFAULT_TIME_BITS = 32;

	localparam int NOW_BITS      = 32;
	localparam int LEFT_BITS     = 32;
	localparam int INTERVAL_BITS = 16;
	localparam int STRIKE_BITS   = 8;
	localparam int SILENCE_BITS  = 20;
	localparam int CFG_DATA_BITS = 20;
	localparam int CFG_IDX_BITS  = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_NORMAL_INTERVAL     = 3'd0,
		CFG_RESTRICTED_INTERVAL = 3'd1,
		CFG_STRIKE_LIMIT        = 3'd2,
		CFG_STRIKE_RELOAD       = 3'd3,
		CFG_SILENCE_LENGTH      = 3'd4
	} mrl_cfg_idx_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic commit;
	} mrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic skip_div;
		logic div_done;
	} mrl_stat_t;

endpackage

>>> src/mrl_if.sv
interface mrl_msg_if import mrl_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [NOW_BITS-1:0] now_seconds;
	logic                sender_restricted;

	modport source(output valid, output now_seconds, output sender_restricted, input ready);
	modport sink(input valid, input now_seconds, input sender_restricted, output ready);
endinterface

interface mrl_verdict_if import mrl_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 blocked;
	logic                 newly_silenced;
	logic [LEFT_BITS-1:0] silence_left;

	modport source(output valid, output blocked, output newly_silenced, output silence_left,
		input ready);
	modport sink(input valid, input blocked, input newly_silenced, input silence_left,
		output ready);
endinterface

>>> src/mrl_dp.sv
module mrl_dp import mrl_pkg::*; #(
	parameter int TIME_BITS = DEFAULT_TIME_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic [NOW_BITS-1:0]      now_seconds,
	input  logic                     sender_restricted,
	input  mrl_cmd_t                 cmd,
	output mrl_stat_t                stat,
	output logic                     blocked,
	output logic                     newly_silenced,
	output logic [LEFT_BITS-1:0]     silence_left
);

	localparam int CNT_BITS = $clog2(TIME_BITS);

	logic [INTERVAL_BITS-1:0] normal_interval_q;
	logic [INTERVAL_BITS-1:0] restricted_interval_q;
	logic [STRIKE_BITS-1:0]   strike_limit_q;
	logic [STRIKE_BITS-1:0]   strike_reload_q;
	logic [SILENCE_BITS-1:0]  silence_length_q;

	logic [TIME_BITS-1:0]     last_time_q;
	logic                     seen_q;
	logic [STRIKE_BITS-1:0]   strike_q;
	logic [TIME_BITS-1:0]     until_q;

	logic [TIME_BITS-1:0]     now_q;
	logic [INTERVAL_BITS-1:0] interval_q;
	logic                     early_q;
	logic [TIME_BITS-1:0]     quot_q;
	logic [INTERVAL_BITS-1:0] rem_q;
	logic [CNT_BITS-1:0]      cnt_q;

	logic [TIME_BITS-1:0]     now_d;
	logic [INTERVAL_BITS-1:0] interval_d;
	logic [TIME_BITS-1:0]     elapsed_d;
	logic                     disabled;
	logic [INTERVAL_BITS:0]   rem_sh;
	logic                     rem_ge;
	logic [STRIKE_BITS-1:0]   strike_mid;
	logic                     silence_new;
	logic                     silence_on;
	logic [TIME_BITS-1:0]     left_wide;
	logic [LEFT_BITS-1:0]     left_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_interval_q     <= '0;
			restricted_interval_q <= '0;
			strike_limit_q        <= '0;
			strike_reload_q       <= '0;
			silence_length_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NORMAL_INTERVAL:     normal_interval_q <= cfg_wdata[INTERVAL_BITS-1:0];
				CFG_RESTRICTED_INTERVAL: restricted_interval_q <= cfg_wdata[INTERVAL_BITS-1:0];
				CFG_STRIKE_LIMIT:        strike_limit_q <= cfg_wdata[STRIKE_BITS-1:0];
				CFG_STRIKE_RELOAD:       strike_reload_q <= cfg_wdata[STRIKE_BITS-1:0];
				CFG_SILENCE_LENGTH:      silence_length_q <= cfg_wdata[SILENCE_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign disabled   = (normal_interval_q == '0) || (strike_limit_q == '0);
	assign now_d      = TIME_BITS'(now_seconds);
	assign interval_d = (restricted_interval_q != '0 && sender_restricted) ?
		restricted_interval_q : normal_interval_q;
	assign elapsed_d  = now_d - last_time_q;

	// one restoring division step: quotient bit shifts in at the bottom of quot_q
	assign rem_sh = {rem_q, quot_q[TIME_BITS-1]};
	assign rem_ge = rem_sh >= {1'b0, interval_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q      <= '0;
			interval_q <= '0;
			cnt_q      <= '0;
		end else if (cmd.load) begin
			rem_q      <= '0;
			interval_q <= interval_d;
			cnt_q      <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? INTERVAL_BITS'(rem_sh - {1'b0, interval_q}) :
				rem_sh[INTERVAL_BITS-1:0];
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q   <= now_d;
			early_q <= elapsed_d < TIME_BITS'(interval_d);
			quot_q  <= elapsed_d;
		end else if (cmd.div_step) begin
			quot_q <= {quot_q[TIME_BITS-2:0], rem_ge};
		end
	end

	assign stat.skip_div = disabled || !seen_q || early_q;
	assign stat.div_done = cnt_q == CNT_BITS'(TIME_BITS - 1);

	always_comb begin
		if (!seen_q) begin
			strike_mid = strike_q;
		end else if (early_q) begin
			strike_mid = (strike_q == '1) ? strike_q : strike_q + 1'b1;
		end else if (quot_q >= TIME_BITS'(strike_q)) begin
			strike_mid = '0;
		end else begin
			strike_mid = strike_q - quot_q[STRIKE_BITS-1:0];
		end
	end

	assign silence_new = strike_mid > strike_limit_q;
	assign silence_on  = until_q > now_q;
	assign left_wide   = silence_new ? TIME_BITS'(silence_length_q) : until_q - now_q;
	assign left_sat    = ((left_wide >> LEFT_BITS) != '0) ? '1 : LEFT_BITS'(left_wide);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			seen_q      <= 1'b0;
			strike_q    <= '0;
			until_q     <= '0;
		end else if (cmd.commit && !disabled) begin
			last_time_q <= now_q;
			seen_q      <= 1'b1;
			if (silence_new) begin
				until_q  <= now_q + TIME_BITS'(silence_length_q);
				strike_q <= strike_reload_q;
			end else begin
				strike_q <= strike_mid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (disabled || !(silence_new || silence_on)) begin
				blocked        <= 1'b0;
				newly_silenced <= 1'b0;
				silence_left   <= '0;
			end else begin
				blocked        <= 1'b1;
				newly_silenced <= silence_new;
				silence_left   <= left_sat;
			end
		end
	end

endmodule

>>> src/mrl_ctrl.sv
module mrl_ctrl import mrl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  mrl_stat_t stat,
	output mrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_DIV    = 3'b010,
		S_COMMIT = 3'b100
	} mrl_state_t;

	mrl_state_t state_q, state_d;
	logic       out_valid_q;

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.div_step = 1'b0;
		cmd.commit   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				if (stat.skip_div) begin
					state_d = S_COMMIT;
				end else begin
					cmd.div_step = 1'b1;
					if (stat.div_done) state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result written over an untaken result");

	a_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DIV && !in_ready))
		else $error("accepted message did not start processing");

	a_commit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT && !cmd.commit) |=> (state_q == S_COMMIT && out_valid_q))
		else $error("stalled result lost");

	a_div_step_only: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (state_q == S_DIV && !stat.skip_div))
		else $error("division step outside division");

endmodule

>>> src/message_rate_limiter.sv
// Strike-counting rate limiter for one message sender. Each transfer on msg is one
// message event at time now_seconds; each produces exactly one transfer on verdict
// telling whether the message is refused, whether it started a new silence, and how
// many seconds of silence remain. A message sooner than one interval after the last
// adds a strike; a later one removes one strike per whole interval elapsed. When
// the count passes strike_limit the sender is silenced for silence_length seconds
// and the count reloads from strike_reload. A zero normal_interval or strike_limit
// passes every message and freezes the state. Configuration goes in through the
// write port (cfg_index as listed in the package); the user must write it only while
// no message is in flight, as the block itself does not enforce this. A message that
// needs the strike decay passes through the one-bit-per-cycle restoring divider that
// works out elapsed time over the interval; first, early or disabled messages skip
// the divider. A new message is taken while the previous verdict still waits in the
// output register; only a verdict that cannot be written holds the controller back.
module message_rate_limiter import mrl_pkg::*; #(
	parameter int TIME_BITS = DEFAULT_TIME_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
	mrl_msg_if.sink                  msg,
	mrl_verdict_if.source            verdict
);

	mrl_cmd_t  cmd;
	mrl_stat_t stat;

	// Sequencer: accept, divide (or skip), then commit the verdict.
	mrl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (msg.valid),
		.in_ready  (msg.ready),
		.out_valid (verdict.valid),
		.out_ready (verdict.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Registers, sender state, divider and the verdict payload.
	mrl_dp #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.now_seconds       (msg.now_seconds),
		.sender_restricted (msg.sender_restricted),
		.cmd               (cmd),
		.stat              (stat),
		.blocked           (verdict.blocked),
		.newly_silenced    (verdict.newly_silenced),
		.silence_left      (verdict.silence_left)
	);

endmodule
